// ===== sv/btt_pkg.sv =====
// Shared types and constants for the blocked task timeout table.
// Request, result and state codes, the table entry layout and the
// controller/datapath command and status bundles. No dependencies.
package btt_pkg;

  localparam int DATA_IN_W  = 112;
  localparam int DATA_OUT_W = 80;
  localparam int TOTAL_W    = 5;
  localparam int RATE_W     = 17;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd1000;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT, exact for every 32-bit x
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  typedef enum logic [1:0] {
    REQ_BLOCK   = 2'd0,
    REQ_UNBLOCK = 2'd1,
    REQ_SWEEP   = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    RES_BLOCKED   = 4'd0,
    RES_ALREADY   = 4'd1,
    RES_FULL      = 4'd2,
    RES_INVALID   = 4'd3,
    RES_UNBLOCKED = 4'd4,
    RES_NOTFOUND  = 4'd5,
    RES_TIMEDOUT  = 4'd6,
    RES_NONE      = 4'd7,
    RES_FOUND     = 4'd8,
    RES_ABSENT    = 4'd9
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_EVAL,
    S_APPEND,
    S_REPLY
  } state_t;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_COUNT,
    MODE_COMPACT
  } mode_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [2:0]  kind;
    logic [31:0] resource;
    logic [31:0] start;
    logic [31:0] timeout;
  } entry_t;

  typedef struct packed {
    logic    capture;
    logic    scan_init;
    logic    rel_clear;
    logic    rd_issue;
    logic    keep;
    logic    drop;
    logic    rel_dec;
    logic    tally;
    logic    append;
    logic    emit;
    logic    emit_last;
    result_t emit_code;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic handle_zero;
    logic scan_end;
    logic hit;
    logic expired;
    logic full;
    logic out_free;
    logic rel_zero;
    logic rel_last;
    logic dropped;
  } sts_t;

endpackage

// ===== sv/blocked_task_timeout_table.sv =====
// Block, unblock and query each load one result; a sweep loads one release per
// expired entry (the last one marked last) or a single none result, and every
// result waits until the output register is free (m_axis_tready takes the one before).
// One request is in work at a time; the next is taken once the last result of the
// current one is loaded, after a scan that reads and then evaluates each entry in turn.
// Reset (rst, synchronous) empties the table and sets the tick rate to 1000.
module blocked_task_timeout_table #(
  parameter int MAX_BLOCKED = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [btt_pkg::RATE_W-1:0]     cfg_wr_data,    // tick_rate_hz
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // handle[7:0], kind[10:8], resource_ident[42:11],
  // wait_ms[74:43], now_tick[106:75], zero fill above
  input  logic [btt_pkg::DATA_IN_W-1:0]  s_axis_tdata,
  input  logic [1:0]                     s_axis_tuser,   // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_handle[7:0], out_kind[10:8], out_resource[42:11],
  // deadline_tick[74:43], blocked_total[79:75]
  output logic [btt_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  output logic [3:0]                     m_axis_tuser,   // status
  output logic                           m_axis_tlast    // last
);

  btt_pkg::cmd_t cmd;
  btt_pkg::sts_t sts;

  btt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  btt_datapath #(
    .MAX_BLOCKED (MAX_BLOCKED)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tuser     (m_axis_tuser),
    .m_tlast     (m_axis_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== sv/btt_ctrl.sv =====
// Controller for the blocked task timeout table: request decode and the
// table scan sequencer. Depends on btt_pkg; drives btt_datapath by commands.
module btt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  btt_pkg::sts_t sts,
  output btt_pkg::cmd_t cmd
);

  btt_pkg::state_t  state, state_next;
  btt_pkg::mode_t   mode, mode_next;
  btt_pkg::result_t reply, reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btt_pkg::S_IDLE;
      mode  <= btt_pkg::MODE_FIND;
      reply <= btt_pkg::RES_NONE;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      reply <= reply_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    reply_next = reply;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      btt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = btt_pkg::S_DECODE;
        end
      end
      btt_pkg::S_DECODE: begin
        case (sts.req)
          btt_pkg::REQ_BLOCK: begin
            if (sts.handle_zero) begin
              reply_next = btt_pkg::RES_INVALID;
              state_next = btt_pkg::S_REPLY;
            end else begin
              cmd.scan_init = 1'b1;
              mode_next     = btt_pkg::MODE_FIND;
              state_next    = btt_pkg::S_READ;
            end
          end
          btt_pkg::REQ_UNBLOCK: begin
            if (sts.handle_zero) begin
              reply_next = btt_pkg::RES_NOTFOUND;
              state_next = btt_pkg::S_REPLY;
            end else begin
              cmd.scan_init = 1'b1;
              mode_next     = btt_pkg::MODE_COMPACT;
              state_next    = btt_pkg::S_READ;
            end
          end
          btt_pkg::REQ_SWEEP: begin
            cmd.scan_init = 1'b1;
            cmd.rel_clear = 1'b1;
            mode_next     = btt_pkg::MODE_COUNT;
            state_next    = btt_pkg::S_READ;
          end
          btt_pkg::REQ_QUERY: begin
            cmd.scan_init = 1'b1;
            mode_next     = btt_pkg::MODE_FIND;
            state_next    = btt_pkg::S_READ;
          end
          default: state_next = btt_pkg::S_IDLE;
        endcase
      end
      btt_pkg::S_READ: begin
        if (sts.scan_end) begin
          case (mode)
            btt_pkg::MODE_FIND: begin
              if (sts.req == btt_pkg::REQ_BLOCK) begin
                if (sts.full) begin
                  reply_next = btt_pkg::RES_FULL;
                  state_next = btt_pkg::S_REPLY;
                end else begin
                  state_next = btt_pkg::S_APPEND;
                end
              end else begin
                reply_next = btt_pkg::RES_ABSENT;
                state_next = btt_pkg::S_REPLY;
              end
            end
            btt_pkg::MODE_COUNT: begin
              if (sts.rel_zero) begin
                reply_next = btt_pkg::RES_NONE;
                state_next = btt_pkg::S_REPLY;
              end else begin
                // second pass: release and compact
                cmd.scan_init = 1'b1;
                mode_next     = btt_pkg::MODE_COMPACT;
              end
            end
            btt_pkg::MODE_COMPACT: begin
              if (sts.req == btt_pkg::REQ_SWEEP) begin
                state_next = btt_pkg::S_IDLE;
              end else begin
                reply_next = sts.dropped ? btt_pkg::RES_UNBLOCKED : btt_pkg::RES_NOTFOUND;
                state_next = btt_pkg::S_REPLY;
              end
            end
            default: state_next = btt_pkg::S_IDLE;
          endcase
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = btt_pkg::S_EVAL;
        end
      end
      btt_pkg::S_EVAL: begin
        case (mode)
          btt_pkg::MODE_FIND: begin
            if (sts.hit) begin
              reply_next = (sts.req == btt_pkg::REQ_BLOCK) ? btt_pkg::RES_ALREADY
                                                           : btt_pkg::RES_FOUND;
              state_next = btt_pkg::S_REPLY;
            end else begin
              state_next = btt_pkg::S_READ;
            end
          end
          btt_pkg::MODE_COUNT: begin
            cmd.tally  = sts.expired;
            state_next = btt_pkg::S_READ;
          end
          btt_pkg::MODE_COMPACT: begin
            if (sts.req == btt_pkg::REQ_SWEEP) begin
              if (sts.expired) begin
                // hold until the output register can take the release
                if (sts.out_free) begin
                  cmd.drop      = 1'b1;
                  cmd.rel_dec   = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_code = btt_pkg::RES_TIMEDOUT;
                  cmd.emit_last = sts.rel_last;
                  state_next    = btt_pkg::S_READ;
                end
              end else begin
                cmd.keep   = 1'b1;
                state_next = btt_pkg::S_READ;
              end
            end else begin
              cmd.drop   = sts.hit;
              cmd.keep   = !sts.hit;
              state_next = btt_pkg::S_READ;
            end
          end
          default: state_next = btt_pkg::S_IDLE;
        endcase
      end
      btt_pkg::S_APPEND: begin
        if (sts.out_free) begin
          cmd.append    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = btt_pkg::RES_BLOCKED;
          cmd.emit_last = 1'b1;
          state_next    = btt_pkg::S_IDLE;
        end
      end
      btt_pkg::S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = reply;
          cmd.emit_last = 1'b1;
          state_next    = btt_pkg::S_IDLE;
        end
      end
      default: state_next = btt_pkg::S_IDLE;
    endcase
  end

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == btt_pkg::S_EVAL) |-> ($past(state) == btt_pkg::S_READ || $past(state) == btt_pkg::S_EVAL))
    else $error("eval entered without a table read");

  a_release_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.rel_dec |-> (cmd.emit && cmd.drop && mode == btt_pkg::MODE_COMPACT))
    else $error("sweep release without a result");

endmodule

// ===== sv/btt_datapath.sv =====
// Datapath for the blocked task timeout table: request registers, the
// entry memory kept in blocking order, the tick converter and the output
// register. Depends on btt_pkg; sequenced by btt_ctrl.
module btt_datapath #(
  parameter int MAX_BLOCKED = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [btt_pkg::RATE_W-1:0]         cfg_wr_data,
  input  logic [btt_pkg::DATA_IN_W-1:0]      s_tdata,
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [btt_pkg::DATA_OUT_W-1:0]     m_tdata,
  output logic [3:0]                         m_tuser,
  output logic                               m_tlast,
  input  btt_pkg::cmd_t                      cmd,
  output btt_pkg::sts_t                      sts
);

  localparam int AW     = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;
  localparam int CW     = $clog2(MAX_BLOCKED + 1);
  localparam int PROD_W = 32 + btt_pkg::RECIP_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKED);

  logic [btt_pkg::RATE_W-1:0] tick_rate;

  btt_pkg::req_t req;
  logic [7:0]    req_handle;
  logic [2:0]    req_kind;
  logic [31:0]   req_resource;
  logic [31:0]   req_ms;
  logic [31:0]   req_now;

  btt_pkg::entry_t mem [MAX_BLOCKED];
  btt_pkg::entry_t rd_data;
  btt_pkg::entry_t new_entry;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_ptr, wr_ptr, n_scan, rel_cnt;
  logic          dropped;

  logic [31:0]       prod_ms;
  logic [PROD_W-1:0] prod_div;
  logic [31:0]       ticks;
  logic [31:0]       elapsed;
  logic              out_free;

  btt_pkg::result_t code;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= btt_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req          <= btt_pkg::req_t'(s_tuser);
      req_handle   <= s_tdata[7:0];
      req_kind     <= s_tdata[10:8];
      req_resource <= s_tdata[42:11];
      req_ms       <= s_tdata[74:43];
      req_now      <= s_tdata[106:75];
    end
  end

  // ms * rate wraps to 32 bits, then divide by 1000 through the reciprocal
  always_ff @(posedge clk) begin
    prod_ms  <= req_ms * 32'(tick_rate);
    prod_div <= PROD_W'(prod_ms) * PROD_W'(btt_pkg::RECIP_1000);
  end

  assign ticks = 32'(prod_div[PROD_W-1:btt_pkg::RECIP_SHIFT]);

  always_comb begin
    new_entry.handle   = req_handle;
    new_entry.kind     = req_kind;
    new_entry.resource = req_resource;
    new_entry.start    = req_now;
    new_entry.timeout  = (req_ms == 32'd0) ? 32'd0 : ticks;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count[AW-1:0]] <= new_entry;
    end else if (cmd.keep) begin
      mem[wr_ptr[AW-1:0]] <= rd_data;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.append) begin
      count_next = count + CW'(1);
    end else if (cmd.drop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      n_scan  <= '0;
      rel_cnt <= '0;
      dropped <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.scan_init) begin
        rd_ptr  <= '0;
        wr_ptr  <= '0;
        n_scan  <= count;
        dropped <= 1'b0;
      end else begin
        if (cmd.rd_issue) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (cmd.keep) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
        if (cmd.drop) begin
          dropped <= 1'b1;
        end
      end
      if (cmd.rel_clear) begin
        rel_cnt <= '0;
      end else if (cmd.tally) begin
        rel_cnt <= rel_cnt + CW'(1);
      end else if (cmd.rel_dec) begin
        rel_cnt <= rel_cnt - CW'(1);
      end
    end
  end

  assign elapsed  = req_now - rd_data.start;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    sts.req         = req;
    sts.handle_zero = (req_handle == 8'd0);
    sts.scan_end    = (rd_ptr == n_scan);
    sts.hit         = (rd_data.handle == req_handle);
    sts.expired     = (rd_data.timeout != 32'd0) && (elapsed >= rd_data.timeout);
    sts.full        = (count >= MAX_CNT);
    sts.out_free    = out_free;
    sts.rel_zero    = (rel_cnt == '0);
    sts.rel_last    = (rel_cnt == CW'(1));
    sts.dropped     = dropped;
  end

  assign code = cmd.emit_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= code;
      m_tlast <= cmd.emit_last;
      case (code)
        btt_pkg::RES_TIMEDOUT: m_tdata[7:0] <= rd_data.handle;
        btt_pkg::RES_NONE:     m_tdata[7:0] <= 8'd0;
        default:               m_tdata[7:0] <= req_handle;
      endcase
      if (code == btt_pkg::RES_FOUND) begin
        m_tdata[10:8]  <= rd_data.kind;
        m_tdata[42:11] <= rd_data.resource;
      end else begin
        m_tdata[10:8]  <= 3'd0;
        m_tdata[42:11] <= 32'd0;
      end
      if (code == btt_pkg::RES_BLOCKED && req_ms != 32'd0) begin
        m_tdata[74:43] <= req_now + ticks;
      end else begin
        m_tdata[74:43] <= 32'd0;
      end
      m_tdata[79:75] <= btt_pkg::TOTAL_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("table count beyond capacity");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    cmd.keep |-> (wr_ptr < rd_ptr))
    else $error("compaction write overtakes the read pointer");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded over a waiting result");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> (count == $past(count) + CW'(1)) && (count <= MAX_CNT))
    else $error("append into a full table");

endmodule
